@@ rtl/u8u16_pkg.sv @@
// Shared types and constants for the UTF-8 to 16-bit code unit decoder.
`timescale 1ns / 1ps

package u8u16_pkg;

    localparam int BYTE_W   = 8;
    localparam int UNIT_W   = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 16;

    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_REPLACED  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_LEAD  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_TRUNCATED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_END       = 3'd4;

    localparam logic [UNIT_W-1:0]  REPLACEMENT_CHAR = 16'hFFFD;
    localparam logic [COUNT_W-1:0] LIMIT_DEFAULT    = 16'hFFFF;
    localparam logic [1:0]         SKIP_FOUR_BYTE   = 2'd3;
    localparam logic [1:0]         PEND_THREE_BYTE  = 2'd2;
    localparam logic [1:0]         PEND_TWO_BYTE    = 2'd1;

    typedef struct packed {
        logic [1:0]         pend;
        logic [UNIT_W-1:0]  acc;
        logic [1:0]         skip;
        logic               halted;
        logic [COUNT_W-1:0] units;
    } t_dec_state;

    typedef struct packed {
        logic                valid;
        logic [UNIT_W-1:0]   code_unit;
        logic [STATUS_W-1:0] status;
        logic                eos;
        logic [COUNT_W-1:0]  count;
    } t_dec_result;

endpackage

@@ rtl/u8u16_step.sv @@
// Per-byte decode logic: next string state and optional result.
`timescale 1ns / 1ps

module u8u16_step (
    input  u8u16_pkg::t_dec_state                 i_state,
    input  logic [u8u16_pkg::BYTE_W-1:0]          i_byte,
    input  logic [u8u16_pkg::COUNT_W-1:0]         i_limit,
    output u8u16_pkg::t_dec_state                 o_state,
    output u8u16_pkg::t_dec_result                o_result
);
    import u8u16_pkg::*;

    logic [COUNT_W-1:0] lim;
    logic [COUNT_W-1:0] units_inc;
    logic [UNIT_W-1:0]  acc_shift;

    assign lim       = (i_limit == '0) ? LIMIT_DEFAULT : i_limit;
    assign units_inc = i_state.units + 1'b1;
    assign acc_shift = {i_state.acc[UNIT_W-7:0], i_byte[5:0]};

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_byte == '0) begin
            o_result.valid = 1'b1;
            o_result.eos   = 1'b1;
            if (i_state.pend != 2'd0) begin
                o_result.code_unit = i_state.acc;
                o_result.status    = STAT_TRUNCATED;
                o_result.count     = units_inc;
            end else begin
                o_result.status = STAT_END;
                o_result.count  = i_state.units;
            end
            o_state = '0;
        end else if (i_state.halted) begin
            o_state = i_state;
        end else if (i_state.pend != 2'd0) begin
            o_state.acc  = acc_shift;
            o_state.pend = i_state.pend - 2'd1;
            if (i_state.pend == 2'd1) begin
                o_state.units      = units_inc;
                o_result.valid     = 1'b1;
                o_result.code_unit = acc_shift;
                o_result.status    = STAT_OK;
                o_result.count     = units_inc;
            end
        end else if (i_state.skip != 2'd0) begin
            o_state.skip = i_state.skip - 2'd1;
        end else if (i_state.units >= lim) begin
            o_state = i_state;
        end else if (!i_byte[7]) begin
            o_state.units      = units_inc;
            o_result.valid     = 1'b1;
            o_result.code_unit = {{(UNIT_W-BYTE_W){1'b0}}, i_byte};
            o_result.status    = STAT_OK;
            o_result.count     = units_inc;
        end else if (i_byte[7:4] == 4'hF) begin
            o_state.skip       = SKIP_FOUR_BYTE;
            o_state.units      = units_inc;
            o_result.valid     = 1'b1;
            o_result.code_unit = REPLACEMENT_CHAR;
            o_result.status    = STAT_REPLACED;
            o_result.count     = units_inc;
        end else if (i_byte[7:5] == 3'b111) begin
            o_state.acc  = {{(UNIT_W-5){1'b0}}, i_byte[4:0]};
            o_state.pend = PEND_THREE_BYTE;
        end else if (i_byte[7:6] == 2'b11) begin
            o_state.acc  = {{(UNIT_W-5){1'b0}}, i_byte[4:0]};
            o_state.pend = PEND_TWO_BYTE;
        end else begin
            o_state.halted     = 1'b1;
            o_state.units      = units_inc;
            o_result.valid     = 1'b1;
            o_result.status    = STAT_BAD_LEAD;
            o_result.count     = units_inc;
        end
    end

endmodule

@@ rtl/u8u16_out_reg.sv @@
// Result register with valid/stall handshake toward the consumer.
`timescale 1ns / 1ps

module u8u16_out_reg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  u8u16_pkg::t_dec_result            i_result,
    input  logic                              i_out_stall,
    output logic                              o_can_load,
    output logic                              o_out_valid,
    output logic [u8u16_pkg::UNIT_W-1:0]      o_code_unit,
    output logic [u8u16_pkg::STATUS_W-1:0]    o_unit_status,
    output logic                              o_end_of_string,
    output logic [u8u16_pkg::COUNT_W-1:0]     o_unit_count
);
    import u8u16_pkg::*;

    logic        r_valid;
    logic        n_valid;
    t_dec_result r_res;

    assign o_can_load = !r_valid || !i_out_stall;
    assign n_valid    = o_can_load ? (i_load && i_result.valid) : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load && i_result.valid) begin
            r_res <= i_result;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_code_unit     = r_res.code_unit;
    assign o_unit_status   = r_res.status;
    assign o_end_of_string = r_res.eos;
    assign o_unit_count    = r_res.count;

endmodule

@@ rtl/utf8_to_utf16_unit_decoder_core.sv @@
// Top level of the UTF-8 to 16-bit code unit decoder.
`timescale 1ns / 1ps

// Decodes a zero-terminated UTF-8 byte stream, one byte per input transaction,
// into 16-bit code units (BMP only; four-byte leads give 0xFFFD and their
// three trailing bytes are dropped). Zero or one result per byte. Throughput is
// one byte per clock while the output is not stalled; a byte passes through the
// input register, the combinational decode and the result register. The unit
// limit register is written through the cfg channel, which is always ready;
// write it only while no transaction is in flight. A value of zero acts as 65535.
module utf8_to_utf16_unit_decoder_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [u8u16_pkg::COUNT_W-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [u8u16_pkg::BYTE_W-1:0]      i_utf8_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [u8u16_pkg::UNIT_W-1:0]      o_code_unit,
    output logic [u8u16_pkg::STATUS_W-1:0]    o_unit_status,
    output logic                              o_end_of_string,
    output logic [u8u16_pkg::COUNT_W-1:0]     o_unit_count
);
    import u8u16_pkg::*;

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic [COUNT_W-1:0] r_limit;
    t_dec_state         r_state;
    t_dec_state         n_state;
    t_dec_result        step_res;
    logic               can_load;
    logic               adv;

    assign o_cfg_ready = 1'b1;
    assign adv         = r_in_valid && can_load;
    assign o_in_stall  = r_in_valid && !can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_DEFAULT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_utf8_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    u8u16_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_limit  (r_limit),
        .o_state  (n_state),
        .o_result (step_res)
    );

    u8u16_out_reg u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (adv),
        .i_result        (step_res),
        .i_out_stall     (i_out_stall),
        .o_can_load      (can_load),
        .o_out_valid     (o_out_valid),
        .o_code_unit     (o_code_unit),
        .o_unit_status   (o_unit_status),
        .o_end_of_string (o_end_of_string),
        .o_unit_count    (o_unit_count)
    );

`ifndef NO_ASSERTIONS
    a_halt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.halted |-> (r_state.pend == 2'd0 && r_state.skip == 2'd0))
        else $error("halted with sequence or skip pending");

    a_pend_skip_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state.pend != 2'd0 && r_state.skip != 2'd0))
        else $error("sequence and skip pending together");

    a_eos_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_of_string) |->
            (o_unit_status == STAT_TRUNCATED || o_unit_status == STAT_END))
        else $error("end of string with unit status");

    a_nul_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_byte == '0) |=>
            (r_state.units == '0 && r_state.pend == 2'd0 && !r_state.halted))
        else $error("string state not cleared after terminator");
`endif

endmodule

@@ dv/utf8_decode_checker.sv @@
`timescale 1ns / 1ps
// Checker for the UTF-8 decoder: predicts code units from the byte stream and compares results.
module utf8_decode_checker
    import u8u16_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [COUNT_W-1:0]  i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [BYTE_W-1:0]   i_utf8_byte,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [UNIT_W-1:0]   i_code_unit,
    input  logic [STATUS_W-1:0] i_unit_status,
    input  logic                i_end_of_string,
    input  logic [COUNT_W-1:0]  i_unit_count,
    output int                  o_mismatch_count,
    output int                  o_units_pending,
    output int                  o_units_checked,
    output int                  o_strings_ended
);

    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] LOW5_MASK  = 8'h1F;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;
    localparam int               REPORT_MAX = 10;

    typedef struct packed {
        logic [UNIT_W-1:0]   unit;
        logic [STATUS_W-1:0] status;
        logic                eos;
        logic [COUNT_W-1:0]  count;
    } unit_rec_t;

    unit_rec_t expected_units[$];

    logic [COUNT_W-1:0] unit_limit;
    logic [1:0]         pend_cnt;
    logic [UNIT_W-1:0]  acc;
    logic [1:0]         skip_cnt;
    logic               stopped;
    logic [COUNT_W-1:0] emitted;

    int mismatches = 0;
    int checked    = 0;
    int ended      = 0;

    task automatic clear_string();
        pend_cnt = '0;
        acc      = '0;
        skip_cnt = '0;
        stopped  = 1'b0;
        emitted  = '0;
    endtask

    task automatic push_unit(input logic [UNIT_W-1:0] u, input logic [STATUS_W-1:0] s,
                             input logic e, input logic [COUNT_W-1:0] c);
        expected_units.push_back('{unit: u, status: s, eos: e, count: c});
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        logic [COUNT_W-1:0] eff_limit;
        eff_limit = (unit_limit == '0) ? LIMIT_DEFAULT : unit_limit;
        if (b == '0) begin
            if (pend_cnt != '0)
                push_unit(acc, STAT_TRUNCATED, 1'b1, emitted + 1'b1);
            else
                push_unit('0, STAT_END, 1'b1, emitted);
            clear_string();
        end else if (stopped) begin
        end else if (pend_cnt != '0) begin
            acc = {acc[UNIT_W-7:0], 6'b0} + UNIT_W'(b & CONT_MASK);
            pend_cnt = pend_cnt - 1'b1;
            if (pend_cnt == '0) begin
                emitted = emitted + 1'b1;
                push_unit(acc, STAT_OK, 1'b0, emitted);
            end
        end else if (skip_cnt != '0) begin
            skip_cnt = skip_cnt - 1'b1;
        end else if (emitted >= eff_limit) begin
        end else if ((b & ASCII_MASK) == '0) begin
            emitted = emitted + 1'b1;
            push_unit(UNIT_W'(b), STAT_OK, 1'b0, emitted);
        end else if ((b & LEAD4_MASK) == LEAD4_MASK) begin
            skip_cnt = SKIP_FOUR_BYTE;
            emitted  = emitted + 1'b1;
            push_unit(REPLACEMENT_CHAR, STAT_REPLACED, 1'b0, emitted);
        end else if ((b & LEAD3_MASK) == LEAD3_MASK) begin
            acc      = UNIT_W'(b & LOW5_MASK);
            pend_cnt = PEND_THREE_BYTE;
        end else if ((b & LEAD2_MASK) == LEAD2_MASK) begin
            acc      = UNIT_W'(b & LOW5_MASK);
            pend_cnt = PEND_TWO_BYTE;
        end else begin
            // stray continuation: bad unit, then ignore until end of string
            stopped = 1'b1;
            emitted = emitted + 1'b1;
            push_unit('0, STAT_BAD_LEAD, 1'b0, emitted);
        end
    endtask

    always @(posedge i_clk) begin
        unit_rec_t want;
        if (!i_rst_n) begin
            unit_limit = LIMIT_DEFAULT;
            clear_string();
            expected_units.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                unit_limit = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                decode_byte(i_utf8_byte);
            if (i_out_valid && !i_out_stall) begin
                if (expected_units.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected transaction: unit %h status %0d eos %0b count %0d",
                                 i_code_unit, i_unit_status, i_end_of_string, i_unit_count);
                end else begin
                    want = expected_units.pop_front();
                    checked++;
                    if (want.eos)
                        ended++;
                    if (want.unit !== i_code_unit || want.status !== i_unit_status ||
                        want.eos !== i_end_of_string || want.count !== i_unit_count) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display({"unit mismatch: expected %h/%0d/%0b/%0d, ",
                                      "got %h/%0d/%0b/%0d (unit/status/eos/count)"},
                                     want.unit, want.status, want.eos, want.count,
                                     i_code_unit, i_unit_status, i_end_of_string,
                                     i_unit_count);
                    end
                end
            end
        end
        o_mismatch_count <= mismatches;
        o_units_pending  <= expected_units.size();
        o_units_checked  <= checked;
        o_strings_ended  <= ended;
    end

endmodule

@@ dv/utf8_to_utf16_unit_decoder_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the UTF-8 decoder: stimulus, handshake pacing, limit changes and verdict.
module utf8_to_utf16_unit_decoder_core_tb;
    import u8u16_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RUN_LIMIT    = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 200;
    localparam int PHASE_BYTES  = 110;
    localparam int HOLD_BYTES   = 60;
    localparam int MAX_GAP      = 18;

    localparam logic [BYTE_W-1:0] STRING_END = 8'h00;
    localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'hF0;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [COUNT_W-1:0]  i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [BYTE_W-1:0]   i_utf8_byte;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [UNIT_W-1:0]   o_code_unit;
    logic [STATUS_W-1:0] o_unit_status;
    logic                o_end_of_string;
    logic [COUNT_W-1:0]  o_unit_count;

    logic rx_draw_stall;
    logic rx_hold;
    bit   rx_burst  = 1'b0;
    bit   tx_burst  = 1'b0;
    bit   tx_locked = 1'b0;

    int cycle_cnt  = 0;
    int bytes_sent = 0;
    int limits_used = 0;
    int mismatch_count;
    int units_pending;
    int units_checked;
    int strings_ended;

    assign i_out_stall = rx_draw_stall | rx_hold;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    utf8_to_utf16_unit_decoder_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_utf8_byte     (i_utf8_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_code_unit     (o_code_unit),
        .o_unit_status   (o_unit_status),
        .o_end_of_string (o_end_of_string),
        .o_unit_count    (o_unit_count)
    );

    utf8_decode_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_utf8_byte      (i_utf8_byte),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_code_unit      (o_code_unit),
        .i_unit_status    (o_unit_status),
        .i_end_of_string  (o_end_of_string),
        .i_unit_count     (o_unit_count),
        .o_mismatch_count (mismatch_count),
        .o_units_pending  (units_pending),
        .o_units_checked  (units_checked),
        .o_strings_ended  (strings_ended)
    );

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d units still expected",
                     cycle_cnt, units_pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_utf8_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    // random characters of every sequence length; noisy strings add junk,
    // truncated sequences and missing terminators
    task automatic send_string(input int n_chars, input bit noisy);
        int kind;
        int conts;
        if (!tx_locked && $urandom_range(0, 5) == 0)
            tx_burst = !tx_burst;
        for (int i = 0; i < n_chars; i++) begin
            kind  = $urandom_range(0, 99);
            conts = 0;
            if (noisy && kind < 15) begin
                send_byte(8'($urandom_range(0, 255)));
            end else if (kind < 45) begin
                send_byte(8'($urandom_range(1, 127)));
            end else if (kind < 65) begin
                send_byte(LEAD2_BITS | 8'($urandom_range(0, 31)));
                conts = 1;
            end else if (kind < 83) begin
                send_byte(LEAD3_BITS | 8'($urandom_range(0, 15)));
                conts = 2;
            end else if (kind < 93) begin
                send_byte(LEAD4_BITS | 8'($urandom_range(0, 15)));
                conts = 3;
            end else begin
                send_byte(CONT_BITS | 8'($urandom_range(0, 63)));
            end
            for (int j = 0; j < conts; j++) begin
                if (noisy && $urandom_range(0, 7) == 0)
                    break;
                if ($urandom_range(0, 9) == 0)
                    send_byte(8'($urandom_range(1, 255)));
                else
                    send_byte(CONT_BITS | 8'($urandom_range(0, 63)));
            end
        end
        if (!noisy || $urandom_range(0, 7) != 0)
            send_byte(STRING_END);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (units_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [COUNT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        limits_used++;
    endtask

    // result side pacing
    initial begin
        int n;
        rx_draw_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 19) == 0)
                rx_burst = !rx_burst;
            n = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (n > 0) begin
                rx_draw_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            rx_draw_stall <= 1'b0;
            @(posedge i_clk);
            while (!(o_out_valid && !i_out_stall)) @(posedge i_clk);
        end
    end

    initial begin
        logic [BYTE_W-1:0] directed_bytes [24];
        logic [COUNT_W-1:0] limit_plan [5];
        int phase_start;
        directed_bytes = '{8'h41, 8'h7F, 8'h01, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                           8'hF0, 8'h9F, 8'h98, 8'h80, 8'hC0, 8'hFF, 8'h00,
                           8'hE2, 8'h82, 8'h00,
                           8'hF0, 8'h41, 8'h00,
                           8'h80, 8'h41, 8'h00};
        limit_plan = '{16'd1, 16'd3, 16'd0, 16'($urandom_range(2, 12)), LIMIT_DEFAULT};

        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_utf8_byte <= '0;
        rx_hold     <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ascii, two/three/four byte, truncation, end inside skip, stray continuation
        foreach (directed_bytes[k])
            send_byte(directed_bytes[k]);
        wait_drained();

        foreach (limit_plan[p]) begin
            cfg_write(limit_plan[p]);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_string($urandom_range(0, 10), $urandom_range(0, 3) == 0);
            wait_drained();
        end

        // long output back-pressure while input keeps coming
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
            begin
                tx_locked   = 1'b1;
                tx_burst    = 1'b1;
                phase_start = bytes_sent;
                while (bytes_sent - phase_start < HOLD_BYTES)
                    send_string($urandom_range(1, 10), 1'b0);
                tx_locked = 1'b0;
            end
        join
        wait_drained();

        $display("sent %0d bytes, checked %0d results over %0d strings",
                 bytes_sent, units_checked, strings_ended);
        $display("unit limit written %0d times, including 1, 0 and 65535", limits_used);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/u8u16_pkg.sv
rtl/u8u16_step.sv
rtl/u8u16_out_reg.sv
rtl/utf8_to_utf16_unit_decoder_core.sv
dv/utf8_decode_checker.sv
dv/utf8_to_utf16_unit_decoder_core_tb.sv
